### hdl/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

    typedef logic [8:0] t_doy;

    localparam logic [22:0] DAY_RECIP     = 23'd6362914;  // floor(2^32 / 675)
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [17:0] YEAR_RECIP    = 18'd183734;   // 2^26 / 365.25
    localparam logic [10:0] HOUR_RECIP    = 11'd1165;     // floor(2^22 / 3600)
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] MIN_RECIP     = 11'd1092;     // floor(2^16 / 60)
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [11:0] FIRST_YEAR    = 12'd1970;
    localparam logic [7:0]  CENTURY_SKIP  = 8'd130;       // 2100, not leap
    localparam logic [7:0]  AFTER_SKIP    = 8'd131;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    localparam logic [3:0]  FEBRUARY      = 4'd1;

    localparam t_doy MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // year index counts from 1970
    function automatic logic is_leap_idx(input logic [7:0] idx);
        return (idx[1:0] == 2'd2) && (idx != CENTURY_SKIP);
    endfunction

    // first day number of year index idx
    function automatic logic [15:0] year_start(input logic [7:0] idx);
        logic [16:0] acc;
        logic [8:0]  plus1;
        plus1 = 9'(idx) + 9'd1;
        acc = 17'(idx) * 17'd365 + 17'(plus1 >> 2) - 17'(idx >= AFTER_SKIP);
        return acc[15:0];
    endfunction

    function automatic t_doy month_start(input logic [3:0] mon, input logic leap);
        t_doy base;
        if (mon > LAST_MONTH) begin
            base = '0;
        end else begin
            base = MONTH_START[mon];
        end
        return base + t_doy'(leap && (mon > FEBRUARY));
    endfunction

endpackage

### hdl/epoch_seconds_to_date.sv
`timescale 1ns / 1ps

// Seconds since 1970-01-01 00:00:00 to Gregorian date and time of day.
// Fully pipelined: one conversion can start every clock, busy never rises,
// and each result appears with o_done. The design has ten register stages:
// each division by a constant (day, year, hour, minute) is a reciprocal
// multiply followed by a one-step correction stage. Results cannot be held
// off; o_done lasts one cycle.
module epoch_seconds_to_date
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_done,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [9:0]  r_vld;

    logic [31:0] r1_secs;

    logic [47:0] n2_prod;
    logic [15:0] r2_q0;
    logic [31:0] r2_secs;

    logic [32:0] n3_prod;
    logic [32:0] n3_rem;
    logic [17:0] r3_rem;
    logic [15:0] r3_q0;

    logic [15:0] n4_days;
    logic [16:0] n4_tod;
    logic [15:0] r4_days;
    logic [16:0] r4_tod;

    logic [34:0] n5_yprod;
    logic [27:0] n5_hprod;
    logic [7:0]  r5_est;
    logic [15:0] r5_days;
    logic [4:0]  r5_h0;
    logic [16:0] r5_tod;

    logic [16:0] n6_hrem;
    logic [15:0] r6_ystart;
    logic [7:0]  r6_est;
    logic [15:0] r6_days;
    logic [4:0]  r6_h0;
    logic [12:0] r6_hrem;

    logic [17:0] n7_diff;
    logic [17:0] n7_wrap;
    logic [7:0]  n7_idx;
    logic        n7_leap;
    t_doy        n7_doy;
    logic [4:0]  n7_hour;
    logic [11:0] n7_msec;
    logic [7:0]  r7_idx;
    logic        r7_leap;
    t_doy        r7_doy;
    logic [4:0]  r7_hour;
    logic [11:0] r7_msec;

    logic [3:0]  n8_mon;
    logic [22:0] n8_mprod;
    logic [3:0]  r8_mon;
    logic [7:0]  r8_idx;
    logic        r8_leap;
    t_doy        r8_doy;
    logic [4:0]  r8_hour;
    logic [11:0] r8_msec;
    logic [5:0]  r8_m0;

    t_doy        n9_dom;
    logic [11:0] n9_srem;
    logic [3:0]  r9_mon;
    logic [7:0]  r9_idx;
    logic [4:0]  r9_day;
    logic [4:0]  r9_hour;
    logic [5:0]  r9_m0;
    logic [6:0]  r9_srem;

    logic [11:0] r10_year;
    logic [3:0]  r10_month;
    logic [4:0]  r10_day;
    logic [4:0]  r10_hour;
    logic [5:0]  r10_minute;
    logic [5:0]  r10_second;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[8:0], start};
        end
    end

    always_comb begin
        n2_prod = 48'(r1_secs[31:7]) * 48'(DAY_RECIP);

        n3_prod = 33'(r2_q0) * 33'(SECS_PER_DAY);
        n3_rem  = 33'(r2_secs) - n3_prod;

        if (r3_rem >= 18'(SECS_PER_DAY)) begin
            n4_days = r3_q0 + 16'd1;
            n4_tod  = 17'(r3_rem - 18'(SECS_PER_DAY));
        end else begin
            n4_days = r3_q0;
            n4_tod  = r3_rem[16:0];
        end

        n5_yprod = 35'(17'(r4_days) + 17'd2) * 35'(YEAR_RECIP);
        n5_hprod = 28'(r4_tod) * 28'(HOUR_RECIP);

        n6_hrem = r5_tod - 17'(r5_h0) * 17'(SECS_PER_HOUR);

        // estimate is the year or the one after it
        n7_diff = 18'(r6_days) - 18'(r6_ystart);
        if (n7_diff[17]) begin
            n7_idx  = r6_est - 8'd1;
            n7_leap = is_leap_idx(n7_idx);
            n7_wrap = n7_diff + 18'd365 + 18'(n7_leap);
            n7_doy  = n7_wrap[8:0];
        end else begin
            n7_idx  = r6_est;
            n7_leap = is_leap_idx(r6_est);
            n7_wrap = n7_diff;
            n7_doy  = n7_diff[8:0];
        end
        if (r6_hrem >= 13'(SECS_PER_HOUR)) begin
            n7_hour = r6_h0 + 5'd1;
            n7_msec = 12'(r6_hrem - 13'(SECS_PER_HOUR));
        end else begin
            n7_hour = r6_h0;
            n7_msec = r6_hrem[11:0];
        end

        n8_mon = '0;
        for (int m = 1; m < 12; m++) begin
            n8_mon = n8_mon + 4'(r7_doy >= month_start(4'(m), r7_leap));
        end
        n8_mprod = 23'(r7_msec) * 23'(MIN_RECIP);

        n9_dom  = r8_doy - month_start(r8_mon, r8_leap) + t_doy'(1);
        n9_srem = r8_msec - 12'(r8_m0) * 12'(SECS_PER_MIN);
    end

    always_ff @(posedge i_clk) begin
        r1_secs <= i_epoch_seconds;

        r2_q0   <= n2_prod[47:32];
        r2_secs <= r1_secs;

        r3_rem <= n3_rem[17:0];
        r3_q0  <= r2_q0;

        r4_days <= n4_days;
        r4_tod  <= n4_tod;

        r5_est  <= n5_yprod[33:26];
        r5_days <= r4_days;
        r5_h0   <= n5_hprod[26:22];
        r5_tod  <= r4_tod;

        r6_ystart <= year_start(r5_est);
        r6_est    <= r5_est;
        r6_days   <= r5_days;
        r6_h0     <= r5_h0;
        r6_hrem   <= n6_hrem[12:0];

        r7_idx  <= n7_idx;
        r7_leap <= n7_leap;
        r7_doy  <= n7_doy;
        r7_hour <= n7_hour;
        r7_msec <= n7_msec;

        r8_mon  <= n8_mon;
        r8_idx  <= r7_idx;
        r8_leap <= r7_leap;
        r8_doy  <= r7_doy;
        r8_hour <= r7_hour;
        r8_msec <= r7_msec;
        r8_m0   <= n8_mprod[21:16];

        r9_mon  <= r8_mon;
        r9_idx  <= r8_idx;
        r9_day  <= n9_dom[4:0];
        r9_hour <= r8_hour;
        r9_m0   <= r8_m0;
        r9_srem <= n9_srem[6:0];

        r10_year  <= FIRST_YEAR + 12'(r9_idx);
        r10_month <= r9_mon + 4'd1;
        r10_day   <= r9_day;
        r10_hour  <= r9_hour;
        if (r9_srem >= 7'(SECS_PER_MIN)) begin
            r10_minute <= r9_m0 + 6'd1;
            r10_second <= 6'(r9_srem - 7'(SECS_PER_MIN));
        end else begin
            r10_minute <= r9_m0;
            r10_second <= r9_srem[5:0];
        end
    end

    assign o_done   = r_vld[9];
    assign o_year   = r10_year;
    assign o_month  = r10_month;
    assign o_day    = r10_day;
    assign o_hour   = r10_hour;
    assign o_minute = r10_minute;
    assign o_second = r10_second;

endmodule

### verif/epoch_seconds_to_date_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_date_tb;

    localparam int unsigned DAY_SECS   = 86400;
    localparam int unsigned HOUR_SECS  = 3600;
    localparam int unsigned MIN_SECS   = 60;
    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned LAST_DAY_NUM = 49709;  // last day with a full 86400 s in range
    localparam int unsigned DRAIN_CYCLES = 40;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_epoch_seconds;
    logic        o_done;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    t_date pending_dates[$];
    int    fail_count    = 0;
    int    sent_count    = 0;
    int    checked_count = 0;

    epoch_seconds_to_date u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_done          (o_done),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic t_date calc_calendar_date(input logic [31:0] secs);
        t_date       d;
        int unsigned day_num;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        day_num = secs / DAY_SECS;
        tod     = secs % DAY_SECS;
        yr      = EPOCH_YEAR;
        forever begin
            span = leap_year(yr) ? 366 : 365;
            if (day_num < span) break;
            day_num -= span;
            yr++;
        end
        mon = 0;
        while (mon < 11) begin
            span = MONTH_DAYS[mon];
            if (mon == 1 && leap_year(yr)) span = 29;
            if (day_num < span) break;
            day_num -= span;
            mon++;
        end
        d.year   = 12'(yr);
        d.month  = 4'(mon + 1);
        d.day    = 5'(day_num + 1);
        d.hour   = 5'(tod / HOUR_SECS);
        d.minute = 6'((tod % HOUR_SECS) / MIN_SECS);
        d.second = 6'(tod % MIN_SECS);
        return d;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result check first, then record the transfer taken at this edge
    always @(posedge i_clk) begin
        t_date exp_d;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_dates.size() == 0) begin
                    $error("o_done with no conversion pending");
                    fail_count++;
                end else begin
                    exp_d = pending_dates.pop_front();
                    compare_field("year",   exp_d.year,   o_year);
                    compare_field("month",  exp_d.month,  o_month);
                    compare_field("day",    exp_d.day,    o_day);
                    compare_field("hour",   exp_d.hour,   o_hour);
                    compare_field("minute", exp_d.minute, o_minute);
                    compare_field("second", exp_d.second, o_second);
                    checked_count++;
                end
            end
            if (start && !busy) begin
                pending_dates.push_back(calc_calendar_date(i_epoch_seconds));
            end
        end
    end

    task automatic send_seconds(input logic [31:0] secs, input bit allow_gap);
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (busy);
        sent_count++;
        if (allow_gap && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_seconds();
        int unsigned day_num;
        day_num = $urandom_range(0, LAST_DAY_NUM);
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return day_num * DAY_SECS + ($urandom_range(0, 1) ? DAY_SECS - 1 : 0);
            default: return $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    task automatic test_calendar_edges();
        logic [31:0] marks [25] = '{
            32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
            32'd2678399, 32'd5097599, 32'd31535999, 32'd31536000,
            32'd68169600, 32'd94608000, 32'd94694399, 32'd94694400,
            32'd951782400, 32'd978220800, 32'd978307199,
            32'd2147483647, 32'd2147483648,
            32'd4107542399, 32'd4107542400, 32'd4133980799,
            32'd4294944000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
        };
        foreach (marks[i]) begin
            send_seconds(marks[i], 1'b1);
        end
    endtask

    task automatic test_random_spread(input int count);
        bit gaps_on;
        gaps_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send_seconds(pick_seconds(), gaps_on);
        end
    endtask

    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++) begin
            send_seconds(pick_seconds(), 1'b0);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_epoch_seconds <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_edges();
        test_random_spread(600);
        test_back_to_back(130);

        start <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d timestamps (calendar edges, random spread with gaps, back-to-back);",
                 sent_count);
        $display("%0d converted dates compared field by field.", checked_count);
        if (fail_count == 0 && pending_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### epoch_seconds_to_date.f
hdl/esd_pkg.sv
hdl/epoch_seconds_to_date.sv
verif/epoch_seconds_to_date_tb.sv
